// ----- rtl/core/bds2x2_pkg.sv -----
// Package: register map and fixed field widths for the 2x2 box downsampler.
`timescale 1ns / 1ps
`default_nettype none

package bds2x2_pkg;

  // Configuration port: two 32-bit registers at byte addresses 0 and 4
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 16;

  // Register index, taken from address bit 2
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(2);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(2);

  // Number of color components per pixel
  localparam int NUM_COMP = 4;

endpackage

`default_nettype wire

// ----- rtl/core/bds2x2_if.sv -----
// Stream interfaces: RGBA input pixel channel and averaged output pixel channel.
`timescale 1ns / 1ps
`default_nettype none

interface bds2x2_in_if #(
  parameter int COMPONENT_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_in;
  logic [COMPONENT_BITS-1:0] green_in;
  logic [COMPONENT_BITS-1:0] blue_in;
  logic [COMPONENT_BITS-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface bds2x2_out_if #(
  parameter int COMPONENT_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_out;
  logic [COMPONENT_BITS-1:0] green_out;
  logic [COMPONENT_BITS-1:0] blue_out;
  logic [COMPONENT_BITS-1:0] alpha_out;
  logic                      frame_last;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/box_downsample_2x2_top.sv -----
// Top level of the 2x2 box-filter downsampler for raster-order RGBA pixels.
//
//  channel  | direction | beat
//  ---------+-----------+--------------------------------------------------
//  in_pix   | sink      | one RGBA input pixel, raster order
//  out_pix  | source    | one averaged RGBA pixel of a 2x2 patch, frame_last
//  p*       | APB slave | image_width at 0x0, image_height at 0x4
//
// One input beat is taken per clock while in_pix.ready is high. The result
// of the odd-column, odd-row pixel that completes a patch passes through the
// registered line-buffer read, then the final add in the output register.
// rst_n (synchronous) clears counters, pair sums and valids; the line buffer
// is not cleared and holds no valid bits. A stalled output holds the pipeline
// and in_pix.ready drops only while both pipeline stages are full.
`timescale 1ns / 1ps
`default_nettype none

module box_downsample_2x2_top #(
  parameter int MAX_WIDTH      = 2048,
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  bds2x2_in_if.sink                                  in_pix,
  bds2x2_out_if.source                               out_pix,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [bds2x2_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [bds2x2_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [bds2x2_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                       pready
);
  import bds2x2_pkg::*;

  localparam int CW         = COMPONENT_BITS;
  localparam int SW         = CW + 1;
  localparam int TW         = CW + 2;
  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW_BITS    = $clog2(MAX_WIDTH + 1);
  localparam int WC_W       = (MW_BITS > WIDTH_BITS) ? MW_BITS : WIDTH_BITS;
  localparam int XC_W       = WC_W + 1;
  localparam int YC_W       = HEIGHT_BITS + 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LA_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  typedef logic [NUM_COMP-1:0][SW-1:0] pair_vec_t;
  typedef logic [NUM_COMP-1:0][CW-1:0] comp_vec_t;

  // Configuration registers
  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  reg_idx_t               cfg_idx;
  logic                   cfg_wr;

  // Position and running pair sums
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [HEIGHT_BITS-1:0] row_r, row_nxt;
  pair_vec_t              pair_r, pair_nxt;

  // Line buffer and its registered read port
  pair_vec_t              line_mem [LINE_DEPTH];
  pair_vec_t              line_q_r;
  logic [LA_W-1:0]        line_addr;

  // Pipeline stage between the read and the output
  logic                   s1_valid_r;
  pair_vec_t              s1_pair_r;
  logic                   s1_last_r;

  // Output register
  logic                   out_valid_r;
  comp_vec_t              out_comp_r, out_comp_nxt;
  logic                   out_last_r;

  comp_vec_t              in_comp;
  logic                   in_acc, adv;
  logic [WC_W-1:0]        w_ext, eff_w, used_w, x_ext;
  logic [HEIGHT_BITS-1:0] used_h;
  logic [XC_W-1:0]        x_inc;
  logic [YC_W-1:0]        y_inc;
  logic                   size_ok, in_area, pair_done, do_write, do_emit, frame_end;

  // APB decode; writes always complete in the access cycle
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes: advance the tail when the output slot is free or drained
  assign adv          = !out_valid_r || out_pix.ready;
  assign in_pix.ready = !s1_valid_r || adv;
  assign in_acc       = in_pix.valid && in_pix.ready;

  assign in_comp[0] = in_pix.red_in;
  assign in_comp[1] = in_pix.green_in;
  assign in_comp[2] = in_pix.blue_in;
  assign in_comp[3] = in_pix.alpha_in;

  // Effective geometry: saturate width, drop odd last column and row
  assign w_ext   = WC_W'(width_r);
  assign eff_w   = (w_ext > WC_W'(MAX_WIDTH)) ? WC_W'(MAX_WIDTH) : w_ext;
  assign used_w  = {eff_w[WC_W-1:1], 1'b0};
  assign used_h  = {height_r[HEIGHT_BITS-1:1], 1'b0};
  assign x_ext   = WC_W'(col_r);
  assign x_inc   = XC_W'(col_r) + XC_W'(1);
  assign y_inc   = YC_W'(row_r) + YC_W'(1);

  assign size_ok   = (eff_w > WC_W'(1)) && (height_r > HEIGHT_BITS'(1));
  assign in_area   = (x_ext < used_w) && (row_r < used_h);
  assign pair_done = in_acc && col_r[0] && size_ok && in_area;
  assign do_write  = pair_done && !row_r[0];
  assign do_emit   = pair_done && row_r[0];
  assign frame_end = (x_inc == XC_W'(used_w)) && (y_inc == YC_W'(used_h));
  assign line_addr = LA_W'(col_r >> 1);

  // Start a pair on even columns, close it on odd columns
  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      if (col_r[0]) begin
        pair_nxt[c] = pair_r[c] + SW'(in_comp[c]);
      end else begin
        pair_nxt[c] = SW'(in_comp[c]);
      end
    end
  end

  // Step column and row, wrapping at the configured sizes
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (x_inc >= XC_W'(eff_w)) begin
      col_nxt = '0;
      if (y_inc >= YC_W'(height_r)) begin
        row_nxt = '0;
      end else begin
        row_nxt = y_inc[HEIGHT_BITS-1:0];
      end
    end else begin
      col_nxt = x_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pair_r <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pair_r <= pair_nxt;
    end
  end

  // Line buffer: store pairs on even rows, fetch them on odd rows
  always_ff @(posedge clk) begin
    if (do_write) begin
      line_mem[line_addr] <= pair_nxt;
    end
    if (do_emit) begin
      line_q_r <= line_mem[line_addr];
    end
  end

  // Stage 1: hold the odd-row pair alongside the fetched line entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= do_emit;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      s1_pair_r <= pair_nxt;
      s1_last_r <= frame_end;
    end
  end

  // Sum the four pixels and divide by four
  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      out_comp_nxt[c] = CW'((TW'(line_q_r[c]) + TW'(s1_pair_r[c])) >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_comp_r <= out_comp_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.red_out    = out_comp_r[0];
  assign out_pix.green_out  = out_comp_r[1];
  assign out_pix.blue_out   = out_comp_r[2];
  assign out_pix.alpha_out  = out_comp_r[3];
  assign out_pix.frame_last = out_last_r;

endmodule

`default_nettype wire
